// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CRB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define CRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/crb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crb_pkg
// Shared widths, codes and bundles for the clipped RGBA blit.
// ---------------------------------------------------------------------------
package crb_pkg;

	localparam int MAX_DIM = 4096;
	localparam int CNT_W   = $clog2(MAX_DIM);
	localparam int DIM_W   = 13;
	localparam int OFS_W   = 14;
	localparam int CH_W    = 3;
	localparam int IDX_W   = 24;

	localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

	// Channel layouts; anything else is RGBA.
	localparam logic [CH_W-1:0] CH_GRAY       = 3'd1;
	localparam logic [CH_W-1:0] CH_GRAY_ALPHA = 3'd2;
	localparam logic [CH_W-1:0] CH_RGB        = 3'd3;

	// Register indexes.
	localparam logic [2:0] REG_DEST_WIDTH   = 3'd0;
	localparam logic [2:0] REG_DEST_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_SRC_WIDTH    = 3'd2;
	localparam logic [2:0] REG_SRC_HEIGHT   = 3'd3;
	localparam logic [2:0] REG_X_OFFSET     = 3'd4;
	localparam logic [2:0] REG_Y_OFFSET     = 3'd5;
	localparam logic [2:0] REG_SRC_CHANNELS = 3'd6;

	// Placement settings, destination size already clamped.
	typedef struct packed {
		logic [DIM_W-1:0]        dw;
		logic [DIM_W-1:0]        dh;
		logic signed [OFS_W-1:0] x_off;
		logic signed [OFS_W-1:0] y_off;
		logic [CH_W-1:0]         channels;
	} place_cfg_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] idx;
		logic [7:0]       r;
		logic [7:0]       g;
		logic [7:0]       b;
		logic [7:0]       a;
	} pix_t;

endpackage

// ===== sv/clipped_rgba_blit_with_alpha_skip.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// clipped_rgba_blit_with_alpha_skip
// Streams source pixels into destination writes with clipping and alpha skip.
// ---------------------------------------------------------------------------
// Usage:
//   Source pixels arrive in raster order on the input channel (in_valid /
//   in_ready, bytes byte0..byte3). Each request gives exactly one result on
//   the output channel (out_valid / out_ready): write_enable, dest_index and
//   the expanded red, green, blue and alpha bytes.
//   Results are registered: an accepted pixel is shown from the next cycle on.
//   Throughput is one pixel per cycle unless the receiver stalls; the single
//   result register is the only stage; it refills in the cycle it is emptied,
//   with the offset add, clip compares and row-times-width multiply before it.
//   A source column and row counter track the pixel position and wrap after
//   the last pixel of the source image.
//   Reset clears the counters and the result valid flag and loads the register
//   defaults (1x1 images, zero offsets, four channels).
//   While the receiver stalls the result is held and no new request is taken.
//   Configuration writes through cfg_we / cfg_addr / cfg_wdata land at once;
//   write them only while the stream is idle.
// ---------------------------------------------------------------------------
module clipped_rgba_blit_with_alpha_skip (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration
	input  logic                      cfg_we,
	input  logic [2:0]                cfg_addr,
	input  logic [crb_pkg::OFS_W-1:0] cfg_wdata,
	// source pixel requests
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                byte0,
	input  logic [7:0]                byte1,
	input  logic [7:0]                byte2,
	input  logic [7:0]                byte3,
	// destination write requests
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      write_enable,
	output logic [crb_pkg::IDX_W-1:0] dest_index,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue,
	output logic [7:0]                alpha
);
	import crb_pkg::*;

	// Configuration registers
	logic [DIM_W-1:0]        dest_width_q, dest_height_q, src_width_q, src_height_q;
	logic signed [OFS_W-1:0] x_offset_q, y_offset_q;
	logic [CH_W-1:0]         src_channels_q;

	// Source position
	logic [CNT_W-1:0] col_q, row_q;

	// Result register
	logic out_valid_q;
	pix_t pix_q;

	logic       in_acc;
	place_cfg_t place_cfg;
	pix_t       pix_d;
	logic [DIM_W-1:0] sw, sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_width_q   <= DIM_W'(1);
			dest_height_q  <= DIM_W'(1);
			src_width_q    <= DIM_W'(1);
			src_height_q   <= DIM_W'(1);
			x_offset_q     <= '0;
			y_offset_q     <= '0;
			src_channels_q <= CH_W'(4);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DEST_WIDTH:   dest_width_q   <= cfg_wdata[DIM_W-1:0];
				REG_DEST_HEIGHT:  dest_height_q  <= cfg_wdata[DIM_W-1:0];
				REG_SRC_WIDTH:    src_width_q    <= cfg_wdata[DIM_W-1:0];
				REG_SRC_HEIGHT:   src_height_q   <= cfg_wdata[DIM_W-1:0];
				REG_X_OFFSET:     x_offset_q     <= $signed(cfg_wdata);
				REG_Y_OFFSET:     y_offset_q     <= $signed(cfg_wdata);
				REG_SRC_CHANNELS: src_channels_q <= cfg_wdata[CH_W-1:0];
				default: ;  // index beyond the register list: drop the write
			endcase
		end
	end

	// Saturate sizes to MAX_DIM; a zero source width or height counts as one,
	// an empty destination simply clips everything.
	always_comb begin
		place_cfg.dw       = (dest_width_q  > MAX_DIM_V) ? MAX_DIM_V : dest_width_q;
		place_cfg.dh       = (dest_height_q > MAX_DIM_V) ? MAX_DIM_V : dest_height_q;
		place_cfg.x_off    = x_offset_q;
		place_cfg.y_off    = y_offset_q;
		place_cfg.channels = src_channels_q;
		sw = (src_width_q  == '0) ? DIM_W'(1) : (src_width_q  > MAX_DIM_V) ? MAX_DIM_V : src_width_q;
		sh = (src_height_q == '0) ? DIM_W'(1) : (src_height_q > MAX_DIM_V) ? MAX_DIM_V : src_height_q;
	end

	// Take a request whenever the result register is empty or being drained.
	assign in_ready = !out_valid_q || out_ready;
	assign in_acc   = in_valid && in_ready;

	crb_xform u_xform (
		.cfg (place_cfg),
		.col (col_q),
		.row (row_q),
		.b0  (byte0),
		.b1  (byte1),
		.b2  (byte2),
		.b3  (byte3),
		.pix (pix_d)
	);

	// Advance the raster position per accepted pixel. A counter left at or
	// past a shrunken size wraps on its next step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if ({1'b0, col_q} + 1'b1 >= sw) begin
				col_q <= '0;
				if ({1'b0, row_q} + 1'b1 >= sh) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload loads only on acceptance, so a stalled result holds.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q <= pix_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign write_enable = pix_q.we;
	assign dest_index   = pix_q.idx;
	assign red          = pix_q.r;
	assign green        = pix_q.g;
	assign blue         = pix_q.b;
	assign alpha        = pix_q.a;

endmodule

// ===== sv/crb_xform.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crb_xform
// Expands one source pixel to RGBA and places it in the destination.
// ---------------------------------------------------------------------------
module crb_xform (
	input  crb_pkg::place_cfg_t      cfg,
	input  logic [crb_pkg::CNT_W-1:0] col,
	input  logic [crb_pkg::CNT_W-1:0] row,
	input  logic [7:0]                b0,
	input  logic [7:0]                b1,
	input  logic [7:0]                b2,
	input  logic [7:0]                b3,
	output crb_pkg::pix_t             pix
);
	import crb_pkg::*;

	localparam int POS_W = OFS_W + 1;

	logic [7:0]              r, g, b, a;
	logic signed [POS_W-1:0] dx, dy;
	logic                    in_x, in_y, we;
	logic [CNT_W+DIM_W-1:0]  prod;
	logic [IDX_W-1:0]        idx;

	always_comb begin
		case (cfg.channels)
			CH_GRAY: begin
				r = b0; g = b0; b = b0; a = 8'hFF;
			end
			CH_GRAY_ALPHA: begin
				r = b0; g = b0; b = b0; a = b1;
			end
			CH_RGB: begin
				r = b0; g = b1; b = b2; a = 8'hFF;
			end
			default: begin
				r = b0; g = b1; b = b2; a = b3;
			end
		endcase
	end

	assign dx = $signed({{(POS_W-CNT_W){1'b0}}, col}) + $signed({cfg.x_off[OFS_W-1], cfg.x_off});
	assign dy = $signed({{(POS_W-CNT_W){1'b0}}, row}) + $signed({cfg.y_off[OFS_W-1], cfg.y_off});

	assign in_x = !dx[POS_W-1] && (dx[POS_W-2:0] < {1'b0, cfg.dw});
	assign in_y = !dy[POS_W-1] && (dy[POS_W-2:0] < {1'b0, cfg.dh});
	assign we   = in_x && in_y && (a != 8'h00);

	// Inside the destination both coordinates are below MAX_DIM.
	assign prod = dy[CNT_W-1:0] * cfg.dw;
	assign idx  = prod[IDX_W-1:0] + {{(IDX_W-CNT_W){1'b0}}, dx[CNT_W-1:0]};

	always_comb begin
		pix.we  = we;
		pix.idx = we ? idx : '0;
		pix.r   = r;
		pix.g   = g;
		pix.b   = b;
		pix.a   = a;
	end

endmodule

// ===== sv/crb_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crb_checker
// Port-level checks on the blit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module crb_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      write_enable,
	input logic [crb_pkg::IDX_W-1:0] dest_index,
	input logic [7:0]                alpha
);

	// A stalled result stays and keeps its index.
	`CRB_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(dest_index), "stalled result changed")

	// An accepted request shows its result on the next cycle.
	`CRB_ASSERT_NEXT(a_one_cycle, in_valid && in_ready, out_valid, "accepted request produced no result")

	// An empty output stage never holds back the input.
	`CRB_ASSERT_SAME(a_empty_ready, !out_valid, in_ready, "input blocked with empty output")

	// A transparent pixel is never written.
	`CRB_ASSERT_SAME(a_alpha_skip, out_valid && write_enable, alpha != 8'h00, "write with zero alpha")

endmodule

bind clipped_rgba_blit_with_alpha_skip crb_checker u_crb_checker (.*);
